// ===== hw/rtl/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the positional list store: operation codes,
// status codes and the command that is broadcast to every list cell.
// ----------------------------------------------------------------------------
package plst_pkg;

   localparam int POS_W       = 8;   // position field
   localparam int OUT_VALUE_W = 32;  // result_value / item_value fields
   localparam int OUT_COUNT_W = 7;   // entry_count field
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BEYOND = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Broadcast to all cells in the cycle a request is taken.
   typedef struct packed {
      logic ins;   // open a slot at the position, shift the tail up
      logic rem;   // close the slot at the position, shift the tail down
   } cell_cmd_type;

endpackage

// ===== hw/rtl/plst_cell.sv =====
// ----------------------------------------------------------------------------
// plst_cell
// One list slot. Holds the value at a fixed list index and moves it to or
// takes it from a neighbor slot when an insert or remove hits at or below it.
// ----------------------------------------------------------------------------
module plst_cell
   import plst_pkg::*;
#(
   parameter int IDX     = 0,
   parameter int VALUE_W = 32,
   parameter int CMP_W   = 8
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [CMP_W-1:0]   pos,         // effective list position
   input  logic [VALUE_W-1:0] new_value,
   input  logic [VALUE_W-1:0] left_value,  // value of slot IDX-1
   input  logic [VALUE_W-1:0] right_value, // value of slot IDX+1
   output logic [VALUE_W-1:0] value,
   output logic [VALUE_W-1:0] sel_value    // own value when addressed, else zero
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               hit;
   logic               above;

   assign hit   = (pos == MY_IDX);
   assign above = (MY_IDX > pos);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (hit) begin
            value_in = new_value;
         end else if (above) begin
            value_in = left_value;
         end
      end else if (cmd.rem) begin
         if (hit || above) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign sel_value = hit ? value_ff : '0;

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to LIST_DEPTH values kept in a row of slot cells.
// Insert, remove and read at a position, each giving one response.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser: func; tdata: position, item_value
//  rsp     | out | rsp_tvalid/tready    | tuser: status; tdata: result_value, entry_count
//
//  One request per cycle while req_tready is high: all cells shift in the cycle
//  the request is taken, and the response is registered for the next cycle.
//  The addressed value is gathered by an OR over all cells into the response.
//  req_tready is high while the response register is empty or being drained;
//  a stalled response holds and blocks only further requests.
//  Synchronous reset empties the list (count only; cells are not cleared).
// ----------------------------------------------------------------------------
module positional_list_store
   import plst_pkg::*;
#(
   parameter int LIST_DEPTH  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] position, [39:8] item_value
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [38:32] entry_count, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

   logic                   fire;
   op_type                 func;
   logic [CMP_W-1:0]       req_pos;
   logic [VALUE_WIDTH-1:0] req_value;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CMP_W-1:0]       count_x;
   logic [CMP_W-1:0]       eff_pos;
   cell_cmd_type           cmd;
   status_type             status;
   logic                   want_value;

   logic                   rsp_valid_ff;
   logic [OUT_VALUE_W-1:0] rsp_value_ff;
   status_type             rsp_status_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic [VALUE_WIDTH-1:0] cell_value [LIST_DEPTH];
   logic [VALUE_WIDTH-1:0] cell_sel   [LIST_DEPTH];
   logic [VALUE_WIDTH-1:0] gathered;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign func       = op_type'(req_tuser);
   assign req_pos    = CMP_W'(req_tdata[POS_W-1:0]);
   assign req_value  = VALUE_WIDTH'(req_tdata[POS_W +: OUT_VALUE_W]);
   assign count_x    = CMP_W'(count_ff);

   // Decode the request: clamp the position, pick the cell command and status.
   always_comb begin
      count_in   = count_ff;
      eff_pos    = req_pos;
      cmd        = '0;
      status     = ST_OK;
      want_value = 1'b0;
      case (func)
         OP_INSERT: begin
            if (count_ff == DEPTH_C) begin
               status = ST_FULL;
            end else begin
               eff_pos  = (req_pos > count_x) ? count_x : req_pos;
               cmd.ins  = fire;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               eff_pos    = (req_pos >= count_x - 1'b1) ? count_x - 1'b1 : req_pos;
               cmd.rem    = fire;
               want_value = 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (req_pos >= count_x) begin
               status = ST_BEYOND;
            end else begin
               want_value = 1'b1;
            end
         end
         default: begin
            // unused code: no change, plain ok response
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_v;
         logic [VALUE_WIDTH-1:0] right_v;
         if (gi == 0) begin : g_first
            assign left_v = req_value;
         end else begin : g_mid_l
            assign left_v = cell_value[gi-1];
         end
         if (gi == LIST_DEPTH - 1) begin : g_last
            assign right_v = cell_value[gi];
         end else begin : g_mid_r
            assign right_v = cell_value[gi+1];
         end
         plst_cell #(
            .IDX     (gi),
            .VALUE_W (VALUE_WIDTH),
            .CMP_W   (CMP_W)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .pos         (eff_pos),
            .new_value   (req_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[gi]),
            .sel_value   (cell_sel[gi])
         );
      end
   endgenerate

   // At most one cell is addressed, so OR the gated values together.
   always_comb begin
      gathered = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         gathered = gathered | cell_sel[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_value_ff  <= want_value ? OUT_VALUE_W'(gathered) : '0;
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, OUT_COUNT_W'(rsp_count_ff), rsp_value_ff};

   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("list count beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      fire && func == OP_INSERT && count_ff != DEPTH_C
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      fire && func == OP_REMOVE && count_ff != '0
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not shrink the list");

   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0)
      else $error("value returned with failing status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> rsp_count_ff == DEPTH_C)
      else $error("full status with list not full");

endmodule

// ===== bench/list_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_store_checker
// Watches the request and response channels of the positional list store,
// keeps its own copy of the list to work out each response, and compares
// every response taken with the oldest one still owed.
// ----------------------------------------------------------------------------
module list_store_checker
   import plst_pkg::*;
#(
   parameter int LIST_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] position, [39:8] item_value
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] result_value, [38:32] entry_count, [39] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct {
      logic [OUT_VALUE_W-1:0] value;
      logic [STATUS_W-1:0]    status;
      logic [OUT_COUNT_W-1:0] count;
   } list_rsp_type;

   logic [OUT_VALUE_W-1:0] list_vals [LIST_DEPTH];
   int                     list_len;
   list_rsp_type           owed_rsps [$];
   list_rsp_type           want_rsp;
   list_rsp_type           seen_rsp;

   // Apply one request to the shadow list and return the response it owes.
   function automatic list_rsp_type apply_list_op(input logic [FUNC_W-1:0] func,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [OUT_VALUE_W-1:0] val);
      list_rsp_type outcome;
      int           slot;
      outcome.value  = '0;
      outcome.status = ST_OK;
      slot = int'(pos);
      case (func)
         OP_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               if (slot > list_len) slot = list_len;
               for (int i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
               list_vals[slot] = val;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (list_len == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               // anything at or past the tail takes the last value
               if (slot >= list_len - 1) slot = list_len - 1;
               outcome.value = list_vals[slot];
               for (int i = slot; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
               list_len--;
            end
         end
         OP_READ: begin
            if (list_len == 0) outcome.status = ST_EMPTY;
            else if (slot >= list_len) outcome.status = ST_BEYOND;
            else outcome.value = list_vals[slot];
         end
         default: ;
      endcase
      outcome.count = OUT_COUNT_W'(list_len);
      return outcome;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         owed_rsps.delete();
      end else begin
         // a response always belongs to an earlier request, so check it first
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.value  = rsp_tdata[31:0];
            seen_rsp.count  = rsp_tdata[38:32];
            seen_rsp.status = rsp_tuser;
            if (owed_rsps.size() == 0) begin
               note_failure($sformatf(
                  "%0t: response with none owed: value %h status %0d count %0d",
                  $realtime, seen_rsp.value, seen_rsp.status, seen_rsp.count));
            end else begin
               want_rsp = owed_rsps.pop_front();
               if (seen_rsp.value !== want_rsp.value || seen_rsp.status !== want_rsp.status
                   || seen_rsp.count !== want_rsp.count)
                  note_failure($sformatf({
                     "%0t: response mismatch: expected value %h status %0d count %0d,",
                     " got value %h status %0d count %0d"},
                     $realtime, want_rsp.value, want_rsp.status, want_rsp.count,
                     seen_rsp.value, seen_rsp.status, seen_rsp.count));
            end
         end
         if (req_tvalid && req_tready)
            owed_rsps.push_back(apply_list_op(req_tuser, req_tdata[7:0], req_tdata[39:8]));
      end
      pending_count = owed_rsps.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, remove and read requests into the positional list store
// with random gaps and response back-pressure; a separate checker predicts
// and compares every response, and this module reports the outcome.
// ----------------------------------------------------------------------------
module tb_top
   import plst_pkg::*;
();

   localparam int              LIST_DEPTH       = 64;
   localparam logic [FUNC_W-1:0] OP_UNUSED      = 2'd3;
   localparam int              CYCLE_LIMIT      = 400000;
   localparam int              LONG_HOLD_CYCLES = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [7:0] position, [39:8] item_value
   logic [1:0]  req_tuser  = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] result_value, [38:32] entry_count, [39] zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   int          mismatch_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          tx_burst    = 1'b0;
   bit          rx_burst    = 1'b0;
   bit          long_hold   = 1'b0;

   positional_list_store #(
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (OUT_VALUE_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   list_store_checker #(
      .LIST_DEPTH (LIST_DEPTH)
   ) chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_list_store verification failed");
         $finish;
      end
   end

   // Response side: random stall before each response, bursts with none,
   // and one long hold-off on request from the stimulus.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
         if (long_hold) begin
            gap = LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end else begin
            gap = rx_burst ? 0 : $urandom_range(0, 14);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                               input logic [OUT_VALUE_W-1:0] val);
      int gap;
      if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {val, pos};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Random requests weighted toward growing or shrinking the list.
   task automatic send_random_ops(input int n, input int ins_pct, input int rem_pct);
      logic [FUNC_W-1:0]      func;
      logic [POS_W-1:0]       pos;
      logic [OUT_VALUE_W-1:0] val;
      int                     pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < ins_pct) func = OP_INSERT;
         else if (pick < ins_pct + rem_pct) func = OP_REMOVE;
         else if (pick < 97) func = OP_READ;
         else func = OP_UNUSED;
         pick = $urandom_range(0, 9);
         if (pick < 7) pos = POS_W'($urandom_range(0, LIST_DEPTH + 8));
         else if (pick < 9) pos = POS_W'($urandom);
         else pos = $urandom_range(0, 1) ? '1 : '0;
         pick = $urandom_range(0, 9);
         if (pick == 0) val = '0;
         else if (pick == 1) val = '1;
         else val = $urandom;
         send_request(func, pos, val);
      end
   endtask

   task automatic wait_for_responses;
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, appends, edges of position and value, tail removal
      send_request(OP_READ,   8'd0,   32'h0000_0000);
      send_request(OP_REMOVE, 8'd0,   32'h0000_0000);
      send_request(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF);
      send_request(OP_INSERT, 8'hFF,  32'hFFFF_FFFF);
      send_request(OP_INSERT, 8'd0,   32'h0000_0000);
      send_request(OP_INSERT, 8'd1,   32'h5A5A_C3C3);
      send_request(OP_INSERT, 8'd200, 32'h1234_5678);
      send_request(OP_READ,   8'd0,   32'hFFFF_FFFF);
      send_request(OP_READ,   8'd1,   32'h0000_0000);
      send_request(OP_READ,   8'd3,   32'h0000_0000);
      send_request(OP_READ,   8'd4,   32'h0000_0000);
      send_request(OP_READ,   8'hFF,  32'h0000_0000);
      send_request(OP_UNUSED, 8'd2,   32'hDEAD_BEEF);
      send_request(OP_REMOVE, 8'hFF,  32'hFFFF_FFFF);
      send_request(OP_REMOVE, 8'd1,   32'h0000_0000);
      send_request(OP_READ,   8'd1,   32'h0000_0000);
      send_request(OP_REMOVE, 8'd3,   32'h0000_0000);
      send_request(OP_REMOVE, 8'd0,   32'h0000_0000);
      send_request(OP_READ,   8'd0,   32'h0000_0000);
      send_request(OP_REMOVE, 8'd0,   32'h0000_0000);
      send_request(OP_INSERT, 8'd0,   32'h8000_0001);

      // fill past full, churn, drain past empty
      repeat (2) begin
         send_random_ops(120, 80, 10);
         send_random_ops(200, 40, 40);
         send_random_ops(120, 10, 75);
         wait_for_responses();
         long_hold = 1'b1;
         send_random_ops(150, 45, 35);
      end
      send_random_ops(150, 75, 15);

      wait_for_responses();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("positional_list_store verification clean");
      end else begin
         $display("positional_list_store verification failed");
      end
      $finish;
   end

endmodule
